FILE: sv/ascp_pkg.sv
package ascp_pkg;

	localparam int BYTE_W  = 8;
	localparam int SKIP_W  = 4;
	localparam int VALUE_W = 16;
	localparam int IN_W    = 8;
	localparam int RES_W   = 5 + BYTE_W + VALUE_W + VALUE_W + BYTE_W;
	localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

	localparam logic [SKIP_W-1:0] NIBBLE_MASK = 4'hf;

	localparam logic [BYTE_W-1:0] CMD_START_UP   = 8'd0;
	localparam logic [BYTE_W-1:0] CMD_START_DOWN = 8'd1;
	localparam logic [BYTE_W-1:0] CMD_MODE       = 8'd2;
	localparam logic [BYTE_W-1:0] CMD_MIN        = 8'd3;
	localparam logic [BYTE_W-1:0] CMD_MAX        = 8'd4;
	localparam logic [BYTE_W-1:0] CMD_ADDRESS    = 8'd5;

	localparam logic [SKIP_W-1:0] BROADCAST_ADDR = 4'd0;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_COMMAND = 2'd1,
		PH_DATA1   = 2'd2,
		PH_DATA2   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [SKIP_W-1:0]  skip_count;
		phase_t             phase;
		logic [BYTE_W-1:0]  held_command;
		logic [BYTE_W-1:0]  high_byte;
		logic [BYTE_W-1:0]  own_address;
		logic [BYTE_W-1:0]  mode_value;
		logic [VALUE_W-1:0] min_value;
		logic [VALUE_W-1:0] max_value;
	} state_t;

	localparam state_t STATE_RESET = '{
		skip_count:   '0,
		phase:        PH_HEADER,
		held_command: '0,
		high_byte:    '0,
		own_address:  8'd1,
		mode_value:   8'd3,
		min_value:    16'd5,
		max_value:    16'd60
	};

	typedef struct packed {
		logic [BYTE_W-1:0]  cur_address;
		logic [VALUE_W-1:0] cur_max;
		logic [VALUE_W-1:0] cur_min;
		logic [BYTE_W-1:0]  cur_mode;
		logic               reschedule_strobe;
		logic               start_up;
		logic               start_strobe;
		logic               delay_strobe;
		logic               skipped;
	} result_t;

endpackage

FILE: sv/ascp_core.sv
module ascp_core (
	input  ascp_pkg::state_t                cur,
	input  logic [ascp_pkg::BYTE_W-1:0]     rx_byte,
	output ascp_pkg::state_t                nxt,
	output ascp_pkg::result_t               res
);
	import ascp_pkg::*;

	logic [SKIP_W-1:0] nib;

	assign nib = rx_byte[SKIP_W-1:0] & NIBBLE_MASK;

	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.skip_count != '0) begin
			nxt.skip_count = cur.skip_count - 4'd1;
			res.skipped = 1'b1;
		end else begin
			res.delay_strobe = 1'b1;
			case (cur.phase)
				PH_HEADER: begin
					if ({4'd0, nib} == cur.own_address || nib == BROADCAST_ADDR)
						nxt.phase = PH_COMMAND;
					else
						nxt.skip_count = rx_byte[BYTE_W-1:SKIP_W];
				end
				PH_COMMAND: begin
					nxt.held_command = rx_byte;
					if (rx_byte == CMD_START_UP || rx_byte == CMD_START_DOWN) begin
						res.start_strobe = 1'b1;
						res.start_up = (rx_byte == CMD_START_UP);
						nxt.phase = PH_HEADER;
					end else begin
						nxt.phase = PH_DATA1;
					end
				end
				PH_DATA1: begin
					nxt.phase = PH_HEADER;
					if (cur.held_command == CMD_MODE) begin
						nxt.mode_value = rx_byte;
						res.reschedule_strobe = 1'b1;
					end else if (cur.held_command == CMD_MIN ||
							cur.held_command == CMD_MAX) begin
						nxt.high_byte = rx_byte;
						nxt.phase = PH_DATA2;
					end else if (cur.held_command == CMD_ADDRESS) begin
						nxt.own_address = rx_byte;
					end
				end
				PH_DATA2: begin
					if (cur.held_command == CMD_MIN)
						nxt.min_value = {cur.high_byte, rx_byte};
					else if (cur.held_command == CMD_MAX)
						nxt.max_value = {cur.high_byte, rx_byte};
					res.reschedule_strobe = 1'b1;
					nxt.phase = PH_HEADER;
				end
				default: begin
					nxt.phase = PH_HEADER;
				end
			endcase
		end
		res.cur_mode    = nxt.mode_value;
		res.cur_min     = nxt.min_value;
		res.cur_max     = nxt.max_value;
		res.cur_address = nxt.own_address;
	end

endmodule

FILE: sv/addressed_serial_command_parser_unit.sv
// Path: a byte accepted into the input register passes the core into the output register, which drives m_axis.
// Throughput: one byte per cycle; an input register and an output register part the
// two sides, so backpressure on m_axis stalls the input only when both are full.
// Reset (arst_n low, asynchronous): both stages empty, skip count and phase cleared,
// address 1, mode 3, minimum 5, maximum 60.
module addressed_serial_command_parser_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ascp_pkg::IN_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] skipped, [1] delay_strobe, [2] start_strobe, [3] start_up,
	// [4] reschedule_strobe, [12:5] cur_mode, [28:13] cur_min,
	// [44:29] cur_max, [52:45] cur_address, [55:53] zero
	output logic [ascp_pkg::OUT_W-1:0]    m_axis_tdata
);
	import ascp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	state_t            state_q;
	state_t            state_nxt;
	result_t           res_nxt;
	logic              advance;

	ascp_core u_core (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata[BYTE_W-1:0];
		if (advance)
			res_s2 <= res_nxt;
	end

endmodule
